// ----- sv/interpolating_sample_store_top_defines.svh -----
// Assertion macros for the interpolating sample store checker.
// Expects signals clk and arst_n in the scope of each use.
`ifndef INTERPOLATING_SAMPLE_STORE_TOP_DEFINES_SVH
`define INTERPOLATING_SAMPLE_STORE_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define ISS_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a condition in the cycle after another follows from it.
`define ISS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/iss_pkg.sv -----
// Shared types and constants of the interpolating sample store.
// No dependencies; used by the top level and its checker.
`default_nettype none

package iss_pkg;

	localparam int DEF_FRAME_DEPTH  = 4096;
	localparam int DEF_MAX_CHANNELS = 2;

	localparam int SMP_W          = 16;
	localparam int WHOLE_W        = 20;
	localparam int FRAC_W         = 16;
	localparam int WIDX_W         = 12;
	localparam int RANGE_W        = 14;
	localparam int CFG_FRAMES_W   = 13;
	localparam int CFG_CHANNELS_W = 2;
	localparam int PADDR_W        = 3;
	localparam int PDATA_W        = 32;
	localparam int PROD_W         = 2 * (SMP_W + 1);
	localparam int ACC_W          = PROD_W + 1;

	localparam logic [CFG_FRAMES_W-1:0]   CFG_FRAMES_RST   = 13'd4096;
	localparam logic [CFG_CHANNELS_W-1:0] CFG_CHANNELS_RST = 2'd1;

	typedef enum logic [1:0] {
		FN_WRITE   = 2'd0,
		FN_CYCLIC  = 2'd1,
		FN_CLAMPED = 2'd2,
		FN_SCAN    = 2'd3
	} func_t;

	typedef enum logic [0:0] {
		REG_FRAMES   = 1'b0,
		REG_CHANNELS = 1'b1
	} reg_t;

endpackage

`default_nettype wire

// ----- sv/interpolating_sample_store_top.sv -----
// Interpolating sample store: a sample memory with a write port, interpolating reads and
// min/max range scans over stored frames. A write transaction gives no result. A clamped
// read passes the states RD_A, RD_B, MUL and FIN; a cyclic read first runs DIV, the bit-serial
// remainder of the location by the frame count, and then the same states. A range scan reads
// one frame per cycle from the single read port of the sample memory, then passes DRAIN and
// FIN; an empty range scan goes straight to FIN. One transaction is in work at a time; a new
// one is accepted while the previous result still waits at the output. The memory is not
// cleared after reset: reading an entry that was never written returns an undefined value.
// Depends on iss_pkg.
`default_nettype none

module interpolating_sample_store_top
	import iss_pkg::*;
#(
	parameter int FRAME_DEPTH  = DEF_FRAME_DEPTH,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [PADDR_W-1:0]        paddr,
	input  wire logic [PDATA_W-1:0]        pwdata,
	output logic      [PDATA_W-1:0]        prdata,
	output logic                           pready,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [1:0]                func,
	input  wire logic [WHOLE_W-1:0]        location_whole,
	input  wire logic [FRAC_W-1:0]         location_fraction,
	input  wire logic                      channel,
	input  wire logic [WIDX_W-1:0]         write_index,
	input  wire logic signed [SMP_W-1:0]   write_sample,
	input  wire logic signed [RANGE_W-1:0] range_start,
	input  wire logic signed [RANGE_W-1:0] range_end,
	input  wire logic signed [SMP_W-1:0]   start_min,
	input  wire logic signed [SMP_W-1:0]   start_max,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed [SMP_W-1:0]        sample_out,
	output logic signed [SMP_W-1:0]        range_min,
	output logic signed [SMP_W-1:0]        range_max
);

	localparam int FRM_W = $clog2(FRAME_DEPTH + 1);
	localparam int FIW   = $clog2(FRAME_DEPTH);
	localparam int CW    = (FRM_W > CFG_FRAMES_W) ? FRM_W : CFG_FRAMES_W;
	localparam int WW    = (FRM_W > WHOLE_W) ? FRM_W : WHOLE_W;
	localparam int DEPTH = FRAME_DEPTH * MAX_CHANNELS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(WHOLE_W);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_DIV   = 8'b0000_0010,
		ST_RD_A  = 8'b0000_0100,
		ST_RD_B  = 8'b0000_1000,
		ST_MUL   = 8'b0001_0000,
		ST_SCAN  = 8'b0010_0000,
		ST_DRAIN = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

	function automatic logic [AW-1:0] store_addr(input logic [FIW-1:0] fr, input logic ch,
			input logic two);
		logic [AW-1:0] a;
		if (two) begin
			a = AW'({fr, ch});
		end else begin
			a = AW'(fr);
		end
		return a;
	endfunction

	logic [CFG_FRAMES_W-1:0]   cfg_frames_q;
	logic [CFG_CHANNELS_W-1:0] cfg_channels_q;
	logic                      cfg_we;

	logic [CW-1:0]    frames_c;
	logic [FRM_W-1:0] frames_eff;
	logic [FRM_W-1:0] frames_m1;
	logic             two_ch;

	state_t state_q, state_d;
	func_t  func_q;
	logic   chan_q;
	logic   in_acc;
	logic   in_chan;

	logic [WHOLE_W-1:0] whole_q;
	logic [FRM_W:0]     rem_q;
	logic [FRM_W:0]     rem_try;
	logic [CNT_W-1:0]   cnt_q;
	logic [FIW-1:0]     first_q;
	logic [FIW-1:0]     first_clamp;
	logic [WW-1:0]      whole_ext;
	logic [FRM_W-1:0]   next_fr;
	logic [FIW-1:0]     second_fr;
	logic [FRAC_W-1:0]  frac_q;

	logic [CW-1:0] scan_start;
	logic [CW-1:0] scan_end;
	logic          scan_empty;
	logic [CW-1:0] s_q;
	logic [CW-1:0] end_q;
	logic          scan_vld_s1;

	logic signed [SMP_W-1:0] lo_q;
	logic signed [SMP_W-1:0] hi_q;
	logic signed [SMP_W-1:0] a_q;
	logic signed [SMP_W:0]   diff;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0] acc;

	logic [SMP_W-1:0] store_q [DEPTH];
	logic [SMP_W-1:0] rd_data_q;
	logic [AW-1:0]    rd_addr;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;

	logic out_valid_q;
	logic out_load;
	logic signed [SMP_W-1:0] sample_q;
	logic signed [SMP_W-1:0] rmin_q;
	logic signed [SMP_W-1:0] rmax_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_frames_q   <= CFG_FRAMES_RST;
			cfg_channels_q <= CFG_CHANNELS_RST;
		end else if (cfg_we) begin
			unique case (reg_t'(paddr[2]))
				REG_FRAMES:   cfg_frames_q   <= pwdata[CFG_FRAMES_W-1:0];
				REG_CHANNELS: cfg_channels_q <= pwdata[CFG_CHANNELS_W-1:0];
				default:      cfg_frames_q   <= cfg_frames_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_t'(paddr[2]))
			REG_FRAMES:   prdata = PDATA_W'(cfg_frames_q);
			REG_CHANNELS: prdata = PDATA_W'(cfg_channels_q);
			default:      prdata = '0;
		endcase
	end

	// effective register values
	always_comb begin
		frames_c = CW'(cfg_frames_q);
		if (frames_c == '0) begin
			frames_c = CW'(1);
		end else if (frames_c > CW'(FRAME_DEPTH)) begin
			frames_c = CW'(FRAME_DEPTH);
		end
	end

	assign frames_eff = FRM_W'(frames_c);
	assign frames_m1  = frames_eff - FRM_W'(1);
	assign two_ch     = (MAX_CHANNELS > 1) && cfg_channels_q[1];

	// input side
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid & ~in_stall;
	assign in_chan  = channel & two_ch;

	assign whole_ext   = WW'(location_whole);
	assign first_clamp = (whole_ext >= WW'(frames_eff)) ? FIW'(frames_m1) : FIW'(location_whole);

	always_comb begin
		scan_start = range_start[RANGE_W-1] ? '0 : CW'(range_start[RANGE_W-2:0]);
		scan_end   = CW'(range_end[RANGE_W-2:0]);
		if (scan_end > CW'(frames_m1)) begin
			scan_end = CW'(frames_m1);
		end
		scan_empty = range_end[RANGE_W-1] || (scan_start > scan_end);
	end

	assign wr_en = in_acc && (func_t'(func) == FN_WRITE)
		&& (CW'(write_index) < CW'(frames_eff)) && !(channel && !two_ch);
	assign wr_addr = store_addr(FIW'(write_index), channel, two_ch);

	// remainder step and second frame
	assign rem_try = {rem_q[FRM_W-1:0], whole_q[WHOLE_W-1]};
	assign next_fr = FRM_W'(first_q) + FRM_W'(1);

	always_comb begin
		if (next_fr == frames_eff) begin
			second_fr = (func_q == FN_CYCLIC) ? '0 : first_q;
		end else begin
			second_fr = FIW'(next_fr);
		end
	end

	always_comb begin
		unique case (state_q)
			ST_RD_B: rd_addr = store_addr(second_fr, chan_q, two_ch);
			ST_SCAN: rd_addr = store_addr(s_q[FIW-1:0], chan_q, two_ch);
			default: rd_addr = store_addr(first_q, chan_q, two_ch);
		endcase
	end

	// sample memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= write_sample;
		end
		rd_data_q <= store_q[rd_addr];
	end

	// control
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (func_t'(func))
						FN_WRITE:   state_d = ST_IDLE;
						FN_CYCLIC:  state_d = ST_DIV;
						FN_CLAMPED: state_d = ST_RD_A;
						FN_SCAN:    state_d = scan_empty ? ST_FIN : ST_SCAN;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_DIV:   state_d = (cnt_q == '0) ? ST_RD_A : ST_DIV;
			ST_RD_A:  state_d = ST_RD_B;
			ST_RD_B:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_FIN;
			ST_SCAN:  state_d = (s_q == end_q) ? ST_DRAIN : ST_SCAN;
			ST_DRAIN: state_d = ST_FIN;
			ST_FIN:   state_d = out_load ? ST_IDLE : ST_FIN;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			scan_vld_s1 <= (state_q == ST_SCAN);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	assign diff = $signed({rd_data_q[SMP_W-1], rd_data_q}) - $signed({a_q[SMP_W-1], a_q});
	assign acc  = $signed({{(ACC_W-SMP_W-FRAC_W){a_q[SMP_W-1]}}, a_q, {FRAC_W{1'b0}}})
		+ $signed({prod_s1[PROD_W-1], prod_s1})
		+ $signed(ACC_W'(1) << (FRAC_W - 1));

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q  <= func_t'(func);
			chan_q  <= in_chan;
			frac_q  <= location_fraction;
			whole_q <= location_whole;
			rem_q   <= '0;
			cnt_q   <= CNT_W'(WHOLE_W - 1);
			first_q <= first_clamp;
			lo_q    <= start_min;
			hi_q    <= start_max;
			s_q     <= scan_start;
			end_q   <= scan_end;
		end
		if (state_q == ST_DIV) begin
			whole_q <= {whole_q[WHOLE_W-2:0], 1'b0};
			cnt_q   <= cnt_q - CNT_W'(1);
			if (rem_try >= {1'b0, frames_eff}) begin
				rem_q <= rem_try - {1'b0, frames_eff};
			end else begin
				rem_q <= rem_try;
			end
			if (cnt_q == '0) begin
				first_q <= (rem_try >= {1'b0, frames_eff})
					? FIW'(rem_try - {1'b0, frames_eff}) : FIW'(rem_try);
			end
		end
		if (state_q == ST_RD_B) begin
			a_q <= rd_data_q;
		end
		if (state_q == ST_MUL) begin
			prod_s1 <= diff * $signed({1'b0, frac_q});
		end
		if (state_q == ST_SCAN) begin
			s_q <= s_q + CW'(1);
		end
		if (scan_vld_s1) begin
			if ($signed(rd_data_q) < lo_q) begin
				lo_q <= rd_data_q;
			end
			if ($signed(rd_data_q) > hi_q) begin
				hi_q <= rd_data_q;
			end
		end
		if (out_load) begin
			if (func_q == FN_SCAN) begin
				sample_q <= '0;
				rmin_q   <= lo_q;
				rmax_q   <= hi_q;
			end else begin
				sample_q <= acc[SMP_W+FRAC_W-1:FRAC_W];
				rmin_q   <= '0;
				rmax_q   <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;
	assign range_min  = rmin_q;
	assign range_max  = rmax_q;

endmodule

`default_nettype wire

// ----- sv/iss_checker.sv -----
// Port-level checker for the interpolating sample store, bound to the top level.
// Depends on iss_pkg and interpolating_sample_store_top_defines.svh.
`default_nettype none

`include "interpolating_sample_store_top_defines.svh"

module iss_checker
	import iss_pkg::*;
(
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    pready,
	input wire logic                    in_valid,
	input wire logic                    in_stall,
	input wire logic [1:0]              func,
	input wire logic                    out_valid,
	input wire logic                    out_stall,
	input wire logic signed [SMP_W-1:0] sample_out,
	input wire logic signed [SMP_W-1:0] range_min,
	input wire logic signed [SMP_W-1:0] range_max
);

	`ISS_ASSERT_ALWAYS(a_pready_high, pready == 1'b1, "pready dropped")

	`ISS_ASSERT_ALWAYS(a_result_fields, !out_valid || (sample_out == '0) || ((range_min == '0) && (range_max == '0)), "result carries both read and scan fields")

	`ISS_ASSERT_NEXT(a_busy_after_request, in_valid && !in_stall && (func_t'(func) != FN_WRITE), in_stall, "request accepted without taking the block busy")

	`ISS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample_out) && $stable(range_min) && $stable(range_max), "stalled result changed")

endmodule

bind interpolating_sample_store_top iss_checker u_iss_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pready     (pready),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.func       (func),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.sample_out (sample_out),
	.range_min  (range_min),
	.range_max  (range_max)
);

`default_nettype wire

// ----- dv/tb_interpolating_sample_store_top.sv -----
// Self-checking testbench for interpolating_sample_store_top: writes, cyclic and clamped
// interpolating reads and min/max range scans, predicted against a shadow sample store.
// Depends on iss_pkg and the top level; drives the APB port and both valid/stall channels.
`default_nettype none

module tb_interpolating_sample_store_top;
	import iss_pkg::*;

	localparam int STORE_DEPTH   = DEF_FRAME_DEPTH * DEF_MAX_CHANNELS;
	localparam int SETTLE_CYCLES = 40;
	localparam int IDLE_LIMIT    = 20000;
	localparam int SCAN_SPAN_CAP = 40;

	typedef struct {
		func_t                     func;
		logic [WHOLE_W-1:0]        whole;
		logic [FRAC_W-1:0]         frac;
		logic                      chan;
		logic [WIDX_W-1:0]         widx;
		logic signed [SMP_W-1:0]   wsample;
		logic signed [RANGE_W-1:0] rstart;
		logic signed [RANGE_W-1:0] rend;
		logic signed [SMP_W-1:0]   lo;
		logic signed [SMP_W-1:0]   hi;
	} request_t;

	typedef struct {
		logic signed [SMP_W-1:0] sample_v;
		logic signed [SMP_W-1:0] lo;
		logic signed [SMP_W-1:0] hi;
	} result_t;

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [PADDR_W-1:0]        paddr;
	logic [PDATA_W-1:0]        pwdata;
	logic [PDATA_W-1:0]        prdata;
	logic                      pready;
	logic                      in_valid;
	logic                      in_stall;
	logic [1:0]                func;
	logic [WHOLE_W-1:0]        location_whole;
	logic [FRAC_W-1:0]         location_fraction;
	logic                      channel;
	logic [WIDX_W-1:0]         write_index;
	logic signed [SMP_W-1:0]   write_sample;
	logic signed [RANGE_W-1:0] range_start;
	logic signed [RANGE_W-1:0] range_end;
	logic signed [SMP_W-1:0]   start_min;
	logic signed [SMP_W-1:0]   start_max;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [SMP_W-1:0]   sample_out;
	logic signed [SMP_W-1:0]   range_min;
	logic signed [SMP_W-1:0]   range_max;

	logic signed [SMP_W-1:0]    shadow_store [0:STORE_DEPTH-1];
	bit                         shadow_written [0:STORE_DEPTH-1];
	logic [CFG_FRAMES_W-1:0]    cfg_frames = CFG_FRAMES_RST;
	logic [CFG_CHANNELS_W-1:0]  cfg_chans  = CFG_CHANNELS_RST;
	result_t                    expected_results [$];
	int                         fail_count   = 0;
	bit                         idle_en      = 1'b1;
	int                         hold_request = 0;

	interpolating_sample_store_top uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int frames_eff();
		int f;
		f = cfg_frames;
		if (f < 1) f = 1;
		if (f > DEF_FRAME_DEPTH) f = DEF_FRAME_DEPTH;
		return f;
	endfunction

	function automatic int chans_eff();
		int c;
		c = cfg_chans;
		if (c < 1) c = 1;
		if (c > DEF_MAX_CHANNELS) c = DEF_MAX_CHANNELS;
		return c;
	endfunction

	function automatic int read_channel(input request_t req);
		int c;
		c = req.chan;
		return (c >= chans_eff()) ? chans_eff() - 1 : c;
	endfunction

	function automatic logic signed [SMP_W-1:0] fetch(input int frame, input int ch);
		return shadow_store[frame * chans_eff() + ch];
	endfunction

	function automatic void read_frames(input request_t req, output int first, output int second);
		int frames;
		frames = frames_eff();
		if (req.func == FN_CYCLIC) begin
			first = req.whole % frames;
			second = first + 1;
			if (second == frames) second = 0;
		end else begin
			first = (req.whole >= frames) ? frames - 1 : int'(req.whole);
			second = first + 1;
			if (second >= frames) second = frames - 1;
		end
	endfunction

	function automatic void scan_bounds(input request_t req, output int rs, output int re);
		rs = req.rstart;
		re = req.rend;
		if (rs < 0) rs = 0;
		if (re >= frames_eff()) re = frames_eff() - 1;
	endfunction

	function automatic logic signed [SMP_W-1:0] lerp_q15(input logic signed [SMP_W-1:0] a,
			input logic signed [SMP_W-1:0] b, input logic [FRAC_W-1:0] f);
		longint acc;
		acc = longint'(a) * (65536 - longint'(f)) + longint'(b) * longint'(f) + 32768;
		return SMP_W'(acc >>> 16);
	endfunction

	function automatic void apply_request(input request_t req);
		int addr, ch, first, second, rs, re, s;
		logic signed [SMP_W-1:0] v;
		result_t r;
		if (req.func == FN_WRITE) begin
			if (req.widx < frames_eff() && req.chan < chans_eff()) begin
				addr = req.widx * chans_eff() + req.chan;
				shadow_store[addr] = req.wsample;
				shadow_written[addr] = 1'b1;
			end
			return;
		end
		ch = read_channel(req);
		if (req.func == FN_SCAN) begin
			r.sample_v = '0;
			r.lo = req.lo;
			r.hi = req.hi;
			scan_bounds(req, rs, re);
			for (s = rs; s <= re; s++) begin
				v = fetch(s, ch);
				if (v < r.lo) r.lo = v;
				if (v > r.hi) r.hi = v;
			end
		end else begin
			read_frames(req, first, second);
			r.sample_v = lerp_q15(fetch(first, ch), fetch(second, ch), req.frac);
			r.lo = '0;
			r.hi = '0;
		end
		expected_results.push_back(r);
	endfunction

	function automatic request_t random_request();
		request_t r;
		r.func    = func_t'($urandom_range(3));
		r.whole   = WHOLE_W'($urandom);
		r.frac    = FRAC_W'($urandom);
		r.chan    = 1'($urandom);
		r.widx    = WIDX_W'($urandom);
		r.wsample = SMP_W'($urandom);
		r.rstart  = RANGE_W'($urandom);
		r.rend    = RANGE_W'($urandom);
		r.lo      = SMP_W'($urandom);
		r.hi      = SMP_W'($urandom);
		return r;
	endfunction

	function automatic void shape_scan(inout request_t req);
		int frames, s, e, rs, re;
		frames = frames_eff();
		req.func = FN_SCAN;
		if ($urandom_range(1)) begin
			s = $urandom_range(frames - 1);
			e = s + $urandom_range(24);
			if (s == 0 && $urandom_range(1))
				req.rstart = RANGE_W'(-$urandom_range(8192, 1));
			else
				req.rstart = RANGE_W'(s);
			if (e >= frames - 1 && $urandom_range(1))
				req.rend = RANGE_W'(frames - 1 + $urandom_range(8191 - (frames - 1)));
			else
				req.rend = RANGE_W'(e);
			if ($urandom_range(1)) begin
				req.lo = 16'sh7FFF;
				req.hi = 16'sh8000;
			end
		end
		scan_bounds(req, rs, re);
		if (re - rs > SCAN_SPAN_CAP) req.rend = RANGE_W'(rs + $urandom_range(SCAN_SPAN_CAP));
	endfunction

	task automatic send_item(input request_t req);
		while (idle_en && $urandom_range(99) < 23) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		func              = req.func;
		location_whole    = req.whole;
		location_fraction = req.frac;
		channel           = req.chan;
		write_index       = req.widx;
		write_sample      = req.wsample;
		range_start       = req.rstart;
		range_end         = req.rend;
		start_min         = req.lo;
		start_max         = req.hi;
		in_valid          = 1'b1;
		do @(posedge clk); while (in_stall);
		apply_request(req);
		@(negedge clk);
	endtask

	task automatic prime(input int frame, input int ch);
		request_t w;
		if (!shadow_written[frame * chans_eff() + ch]) begin
			w = random_request();
			w.func = FN_WRITE;
			w.widx = WIDX_W'(frame);
			w.chan = 1'(ch);
			send_item(w);
		end
	endtask

	// Write any not yet written entry the request will read before sending it.
	task automatic issue(input request_t req);
		int ch, first, second, rs, re, s;
		if (req.func != FN_WRITE) begin
			ch = read_channel(req);
			if (req.func == FN_SCAN) begin
				scan_bounds(req, rs, re);
				for (s = rs; s <= re; s++) prime(s, ch);
			end else begin
				read_frames(req, first, second);
				prime(first, ch);
				prime(second, ch);
			end
		end
		send_item(req);
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input reg_t which, input logic [PDATA_W-1:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = PADDR_W'(int'(which) * 4);
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (which)
			REG_FRAMES:   cfg_frames = value[CFG_FRAMES_W-1:0];
			REG_CHANNELS: cfg_chans  = value[CFG_CHANNELS_W-1:0];
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic set_config(input int frames, input int chans);
		wait_idle();
		write_reg(REG_FRAMES, PDATA_W'(frames));
		write_reg(REG_CHANNELS, PDATA_W'(chans));
	endtask

	task automatic test_defaults_after_reset();
		request_t r;
		r = random_request(); r.func = FN_WRITE; r.widx = '0; r.chan = 1'b0;
		r.wsample = 16'sh8000; issue(r);
		r = random_request(); r.func = FN_WRITE; r.widx = '1; r.chan = 1'b0;
		r.wsample = 16'sh7FFF; issue(r);
		r = random_request(); r.func = FN_WRITE; r.widx = 12'd1; r.chan = 1'b1; issue(r);
		r = random_request(); r.func = FN_CYCLIC; r.whole = '1; r.frac = '1; issue(r);
		r = random_request(); r.func = FN_CYCLIC; r.whole = 20'd4095; r.frac = '0;
		r.chan = 1'b1; issue(r);
		r = random_request(); r.func = FN_CLAMPED; r.whole = '1; r.frac = 16'h8000; issue(r);
		r = random_request(); r.func = FN_CLAMPED; r.whole = '0; r.frac = '1; issue(r);
		r = random_request(); r.func = FN_SCAN; r.rstart = 14'sh2000; r.rend = 14'sd1;
		r.chan = 1'b1; r.lo = 16'sh7FFF; r.hi = 16'sh8000; issue(r);
		r = random_request(); r.func = FN_SCAN; r.rstart = 14'sd4094; r.rend = 14'sh1FFF;
		r.lo = '0; r.hi = '0; issue(r);
		r = random_request(); r.func = FN_SCAN; r.rstart = 14'sh1FFF; r.rend = 14'sh2000;
		r.lo = 16'sh8000; r.hi = 16'sh7FFF; issue(r);
	endtask

	task automatic test_register_extremes();
		request_t r;
		set_config(1, 2);
		r = random_request(); r.func = FN_WRITE; r.widx = '0; r.chan = 1'b1;
		r.wsample = 16'sh7FFF; issue(r);
		r = random_request(); r.func = FN_WRITE; r.widx = 12'd5; issue(r);
		r = random_request(); r.func = FN_CYCLIC; r.whole = '1; issue(r);
		r = random_request(); r.func = FN_CLAMPED; r.whole = 20'd7; r.chan = 1'b1; issue(r);
		r = random_request(); r.func = FN_SCAN; r.rstart = 14'sh2000; r.rend = 14'sh1FFF;
		r.chan = 1'b1; issue(r);
		set_config(0, 0);
		r = random_request(); r.func = FN_WRITE; r.widx = '0; r.chan = 1'b1; issue(r);
		r = random_request(); r.func = FN_CYCLIC; r.chan = 1'b1; issue(r);
		r = random_request(); r.func = FN_SCAN; r.rstart = 14'sh2000; r.rend = 14'sh1FFF; issue(r);
		set_config(8191, 3);
		r = random_request(); r.func = FN_WRITE; r.widx = '1; r.chan = 1'b1;
		r.wsample = 16'sh8000; issue(r);
		r = random_request(); r.func = FN_CYCLIC; r.whole = '1; r.frac = 16'd1;
		r.chan = 1'b1; issue(r);
		r = random_request(); r.func = FN_CLAMPED; r.whole = 20'd4096; r.chan = 1'b0; issue(r);
		set_config(8, 2);
		r = random_request(); r.func = FN_WRITE; r.widx = '1; issue(r);
		r = random_request(); r.func = FN_SCAN; r.rstart = 14'sh2000; r.rend = 14'sh1FFF;
		r.chan = 1'b1; issue(r);
		r = random_request(); r.func = FN_CLAMPED; r.whole = 20'd7; r.frac = '1; issue(r);
	endtask

	task automatic test_random_traffic();
		int set_frames [8] = '{4096, 1, 2, 37, 4096, 64, 3, 0};
		int set_chans  [8] = '{2, 1, 2, 1, 1, 2, 2, 0};
		int k, n, pick, frames;
		request_t r;
		for (k = 0; k < 8; k++) begin
			if (k == 7)
				set_config($urandom_range(4096, 1), $urandom_range(2, 1));
			else
				set_config(set_frames[k], set_chans[k]);
			idle_en = (k != 4);
			frames = frames_eff();
			for (n = 0; n < 24; n++) begin
				r = random_request();
				pick = $urandom_range(99);
				if (pick < 30) begin
					r.func = FN_WRITE;
					if ($urandom_range(99) < 70) r.widx = WIDX_W'($urandom_range(frames - 1));
				end else if (pick < 55) begin
					r.func = FN_CYCLIC;
					if ($urandom_range(99) < 40) r.whole = WHOLE_W'($urandom_range(2 * frames));
				end else if (pick < 75) begin
					r.func = FN_CLAMPED;
					if ($urandom_range(1)) r.whole = WHOLE_W'($urandom_range(frames + 1));
				end else begin
					shape_scan(r);
				end
				issue(r);
			end
		end
		idle_en = 1'b1;
	endtask

	task automatic test_output_backpressure();
		int n;
		request_t r;
		wait_idle();
		idle_en = 1'b0;
		hold_request = 300;
		for (n = 0; n < 40; n++) begin
			r = random_request();
			if (n % 2 == 0) r.func = FN_CLAMPED;
			else shape_scan(r);
			issue(r);
		end
		idle_en = 1'b1;
	endtask

	// Receiver: random stall, or a long hold when requested.
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = idle_en && ($urandom_range(99) < 23);
			end
		end
	end

	initial begin
		result_t got, want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.sample_v = sample_out;
				got.lo = range_min;
				got.hi = range_max;
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result transaction: sample %0d min %0d max %0d",
							got.sample_v, got.lo, got.hi);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (got.sample_v !== want.sample_v || got.lo !== want.lo ||
							got.hi !== want.hi) begin
						if (fail_count < 10)
							$display("mismatch: sample %0d/%0d min %0d/%0d max %0d/%0d (exp/act)",
								want.sample_v, got.sample_v, want.lo, got.lo, want.hi, got.hi);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_interpolating_sample_store_top: done, errors");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		in_valid          = 1'b0;
		func              = FN_WRITE;
		location_whole    = '0;
		location_fraction = '0;
		channel           = 1'b0;
		write_index       = '0;
		write_sample      = '0;
		range_start       = '0;
		range_end         = '0;
		start_min         = '0;
		start_max         = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_defaults_after_reset();
		test_register_extremes();
		test_random_traffic();
		test_output_backpressure();
		wait_idle();
		if (expected_results.size() != 0) fail_count++;
		if (fail_count == 0)
			$display("tb_interpolating_sample_store_top: done, clean");
		else
			$display("tb_interpolating_sample_store_top: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
